### design/lsfr_pkg.sv
// Package for the LED strand frame remapper: sizes, codes, board map table
// and the physical-to-virtual pixel lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsfr_pkg;

  localparam int StoreDepth   = 1024;
  localparam int StoreAw      = $clog2(StoreDepth);
  localparam int EdgePixels   = 158;
  localparam int EdgeHalf     = EdgePixels / 2;
  localparam int EdgeBase     = 700;
  localparam int StringPixels = 702;
  localparam int PixAw        = $clog2(StringPixels);
  localparam int SrcW         = 13;
  localparam int NumSegs      = 10;

  typedef enum logic [2:0] {
    MODE_WR_IDX = 3'd0,
    MODE_WR_XY  = 3'd1,
    MODE_RD_IDX = 3'd2,
    MODE_RD_XY  = 3'd3,
    MODE_SHIFT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CFG_GRB_ORDER  = 3'd0,
    CFG_SIDE_ON    = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_PIX_COUNT  = 3'd3,
    CFG_BRIGHTNESS = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_ACCESS,
    ST_RDWAIT,
    ST_SRC,
    ST_SRCWAIT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    DIV_ROW,
    DIV_LVL,
    DIV_BYTE
  } div_use_e;

  typedef struct packed {
    logic             found;
    logic [SrcW-1:0]  v;
  } src_t;

  // Board map segments: virtual range lo..hi lands at physical out..out+len
  localparam logic [SrcW-1:0] SegLo [NumSegs] = '{
    13'd20, 13'd83, 13'd146, 13'd213, 13'd281,
    13'd351, 13'd423, 13'd496, 13'd573, 13'd650};
  localparam logic [SrcW-1:0] SegHi [NumSegs] = '{
    13'd50, 13'd127, 13'd205, 13'd278, 13'd350,
    13'd420, 13'd488, 13'd555, 13'd617, 13'd680};
  localparam logic [SrcW-1:0] SegOut [NumSegs] = '{
    13'd1, 13'd32, 13'd77, 13'd137, 13'd203,
    13'd273, 13'd343, 13'd409, 13'd469, 13'd514};
  localparam logic SegDown [NumSegs] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  function automatic logic [23:0] swap_hi(logic [23:0] c);
    return {c[15:8], c[23:16], c[7:0]};
  endfunction

  // Virtual pixel shown at physical pixel q; later matches override earlier.
  function automatic src_t source_of(logic [PixAw-1:0] q, logic side_on,
                                     logic [10:0] pcount);
    src_t            r;
    logic [SrcW-1:0] np, m, lim, len, d, px, t;
    r.found = 1'b0;
    r.v     = '0;
    np  = SrcW'(q) + SrcW'(1);
    lim = (SrcW'(pcount) < SrcW'(StoreDepth)) ? SrcW'(pcount) : SrcW'(StoreDepth);
    if (side_on) begin
      m = (np > SrcW'(EdgePixels)) ? np - SrcW'(EdgePixels) : '0;
    end else begin
      m = np;
    end
    for (int i = 0; i < NumSegs; i++) begin
      len = SegHi[i] - SegLo[i];
      d   = m - SegOut[i];
      px  = SegDown[i] ? SegHi[i] - d : SegLo[i] + d;
      if (m != '0 && m >= SegOut[i] && m <= SegOut[i] + len &&
          px - SrcW'(1) < lim) begin
        r.found = 1'b1;
        r.v     = px - SrcW'(1);
      end
    end
    if (side_on) begin
      if (np - SrcW'(1) < SrcW'(EdgeHalf) &&
          SrcW'(EdgeBase) + np - SrcW'(1) < lim) begin
        r.found = 1'b1;
        r.v     = SrcW'(EdgeBase) + np - SrcW'(1);
      end
      t = SrcW'(EdgePixels + EdgeHalf) - np;
      if (np <= SrcW'(EdgePixels) && SrcW'(EdgeBase) + t < lim) begin
        r.found = 1'b1;
        r.v     = SrcW'(EdgeBase) + t;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/lsfr_ram.sv
// Generic single-clock RAM, one write and one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsfr_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### design/led_strand_frame_remapper.sv
// LED strand frame remapper top level: frame store, x,y addressing, board map
// shift-out with brightness scaling. Depends on lsfr_pkg and lsfr_ram.
// Index writes pass ST_ACCESS then ST_FIN; index reads ST_ACCESS, ST_RDWAIT, ST_FIN. x,y modes
// first run the 16-step shared divider for y mod height (skipped at zero height), then ST_ADDR.
// Shift step: ST_SRC, ST_SRCWAIT and ST_FIN when the position is unmapped or the level is 0;
// otherwise 255/level then byte/divisor run on the same serial divider before ST_FIN.
// One transaction in flight; the next start is taken the cycle after done_o.
// After reset the store is swept to zero with busy_o high.
`timescale 1ns / 1ps
`default_nettype none

module led_strand_frame_remapper
  import lsfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [15:0] pixel_index_i,
  input  wire logic [15:0] x_coord_i,
  input  wire logic [15:0] y_coord_i,
  input  wire logic [23:0] color_i,
  output logic             done_o,
  output logic [23:0]      read_color_o,
  output logic [7:0]       out_byte_o,
  output logic             last_byte_o
);

  // configuration
  logic        grb_q, side_q;
  logic [9:0]  height_q;
  logic [10:0] pcount_q;
  logic [7:0]  level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grb_q    <= 1'b0;
      side_q   <= 1'b1;
      height_q <= 10'd10;
      pcount_q <= 11'd858;
      level_q  <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRB_ORDER:  grb_q    <= cfg_wdata_i[0];
        CFG_SIDE_ON:    side_q   <= cfg_wdata_i[0];
        CFG_HEIGHT:     height_q <= cfg_wdata_i[9:0];
        CFG_PIX_COUNT:  pcount_q <= cfg_wdata_i;
        CFG_BRIGHTNESS: level_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  state_e             state_q, state_d;
  div_use_e           use_q, use_d;
  logic [2:0]         mode_q, mode_d;
  logic [15:0]        idx_q, idx_d, x_q, x_d, row_q, row_d;
  logic [23:0]        color_q, color_d;
  logic [15:0]        dq_q, dq_d;
  logic [9:0]         rem_q, rem_d, dsr_q, dsr_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               found_q, found_d;
  logic [7:0]         byte_q, byte_d;
  logic [PixAw-1:0]   pix_q, pix_d;
  logic [1:0]         k_q, k_d;
  logic [StoreAw-1:0] clr_q, clr_d;
  logic [23:0]        res_color_q, res_color_d;
  logic [7:0]         res_byte_q, res_byte_d;
  logic               res_last_q, res_last_d;

  // memory port
  logic               ram_we;
  logic [StoreAw-1:0] ram_waddr, ram_raddr;
  logic [23:0]        ram_wdata, ram_rdata;

  // datapath helpers
  logic [10:0] trial;
  logic        trial_ge;
  logic [9:0]  step_rem;
  logic [15:0] step_dq;
  logic [25:0] addr_sum;
  logic        in_range;
  src_t        src;
  logic [7:0]  sel_byte;
  logic        is_write;

  lsfr_ram #(
    .Width(24),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pix_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pix_q   <= pix_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    use_q       <= use_d;
    mode_q      <= mode_d;
    idx_q       <= idx_d;
    x_q         <= x_d;
    row_q       <= row_d;
    color_q     <= color_d;
    dq_q        <= dq_d;
    rem_q       <= rem_d;
    dsr_q       <= dsr_d;
    cnt_q       <= cnt_d;
    found_q     <= found_d;
    byte_q      <= byte_d;
    res_color_q <= res_color_d;
    res_byte_q  <= res_byte_d;
    res_last_q  <= res_last_d;
  end

  // one restoring step of the shared divider
  assign trial    = {rem_q, dq_q[15]};
  assign trial_ge = trial >= {1'b0, dsr_q};
  assign step_rem = trial_ge ? 10'(trial - {1'b0, dsr_q}) : trial[9:0];
  assign step_dq  = {dq_q[14:0], trial_ge};

  assign addr_sum = {10'd0, row_q} + (26'(x_q) * 26'(height_q));
  assign in_range = (idx_q < {5'd0, pcount_q}) && (idx_q < 16'(StoreDepth));
  assign src      = source_of(pix_q, side_q, pcount_q);
  assign is_write = (mode_q == MODE_WR_IDX) || (mode_q == MODE_WR_XY);

  always_comb begin
    unique case (k_q)
      2'd0:    sel_byte = ram_rdata[23:16];
      2'd1:    sel_byte = ram_rdata[15:8];
      default: sel_byte = ram_rdata[7:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    use_d       = use_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    x_d         = x_q;
    row_d       = row_q;
    color_d     = color_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    byte_d      = byte_q;
    pix_d       = pix_q;
    k_d         = k_q;
    clr_d       = clr_q;
    res_color_d = res_color_q;
    res_byte_d  = res_byte_q;
    res_last_d  = res_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[StoreAw-1:0];
    ram_wdata   = grb_q ? swap_hi(color_q) : color_q;
    ram_raddr   = idx_q[StoreAw-1:0];
    busy_o      = 1'b1;
    done_o      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + StoreAw'(1);
        if (clr_q == StoreAw'(StoreDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          mode_d      = mode_i;
          idx_d       = pixel_index_i;
          x_d         = x_coord_i;
          color_d     = color_i;
          res_color_d = '0;
          res_byte_d  = '0;
          res_last_d  = 1'b0;
          dq_d        = y_coord_i;
          rem_d       = '0;
          dsr_d       = height_q;
          cnt_d       = '0;
          use_d       = DIV_ROW;
          row_d       = y_coord_i;
          priority if (mode_i == MODE_WR_IDX || mode_i == MODE_RD_IDX) begin
            state_d = ST_ACCESS;
          end else if (mode_i == MODE_WR_XY || mode_i == MODE_RD_XY) begin
            // zero height: the row is y itself
            state_d = (height_q == '0) ? ST_ADDR : ST_DIV;
          end else if (mode_i == MODE_SHIFT) begin
            state_d = ST_SRC;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_DIV: begin
        dq_d  = step_dq;
        rem_d = step_rem;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          cnt_d = '0;
          rem_d = '0;
          unique case (use_q)
            DIV_ROW: begin
              row_d   = {6'd0, step_rem};
              state_d = ST_ADDR;
            end
            DIV_LVL: begin
              // divisor = 255/level, now scale the byte by it
              dq_d  = {8'd0, byte_q};
              dsr_d = {2'd0, step_dq[7:0]};
              use_d = DIV_BYTE;
            end
            default: begin
              res_byte_d = step_dq[7:0];
              state_d    = ST_FIN;
            end
          endcase
        end
      end

      ST_ADDR: begin
        idx_d   = addr_sum[15:0];
        state_d = ST_ACCESS;
      end

      ST_ACCESS: begin
        if (is_write) begin
          ram_we  = in_range;
          state_d = ST_FIN;
        end else begin
          found_d = in_range;
          state_d = ST_RDWAIT;
        end
      end

      ST_RDWAIT: begin
        res_color_d = found_q ? (grb_q ? swap_hi(ram_rdata) : ram_rdata) : '0;
        state_d     = ST_FIN;
      end

      ST_SRC: begin
        ram_raddr = src.v[StoreAw-1:0];
        found_d   = src.found;
        state_d   = ST_SRCWAIT;
      end

      ST_SRCWAIT: begin
        res_last_d = (pix_q == PixAw'(StringPixels - 1)) && (k_q == 2'd2);
        byte_d     = sel_byte;
        rem_d      = '0;
        cnt_d      = '0;
        priority if (!found_q) begin
          res_byte_d = '0;
          state_d    = ST_FIN;
        end else if (level_q == '0) begin
          // divisor is 255: only a full-scale byte gives one
          res_byte_d = {7'd0, sel_byte == 8'hFF};
          state_d    = ST_FIN;
        end else begin
          dq_d    = 16'd255;
          dsr_d   = {2'd0, level_q};
          use_d   = DIV_LVL;
          state_d = ST_DIV;
        end
      end

      ST_FIN: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
        if (mode_q == MODE_SHIFT) begin
          if (k_q == 2'd2) begin
            k_d   = '0;
            pix_d = (pix_q == PixAw'(StringPixels - 1)) ? '0 : pix_q + PixAw'(1);
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign read_color_o = res_color_q;
  assign out_byte_o   = res_byte_q;
  assign last_byte_o  = res_last_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_color_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && read_color_o != '0) |->
      (mode_q == MODE_RD_IDX || mode_q == MODE_RD_XY))
    else $error("read colour returned outside a read transaction");

  a_byte_only_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_byte_o != '0 || last_byte_o)) |-> (mode_q == MODE_SHIFT))
    else $error("shift output outside a shift transaction");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && last_byte_o) |=> (pix_q == '0 && k_q == '0))
    else $error("shift position did not wrap after the final byte");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != 2'd3)
    else $error("byte-in-pixel counter out of range");

endmodule

`default_nettype wire

### tb/tb_led_strand_frame_remapper.sv
// Self-checking testbench for led_strand_frame_remapper: a queue-fed command
// driver, a result monitor and a board map predictor with its own frame store.
// Depends on lsfr_pkg and the remapper RTL only.
`timescale 1ns / 1ps

module tb_led_strand_frame_remapper;
  import lsfr_pkg::*;

  localparam int unsigned FrameBytes = 3 * StringPixels;
  localparam int          StallLimit = 20000;
  localparam int          PhaseItems = 56;

  // Board runs: virtual first..last land on physical base..base+len
  localparam int unsigned RunFirst [10] = '{20, 83, 146, 213, 281, 351, 423, 496, 573, 650};
  localparam int unsigned RunLast  [10] = '{50, 127, 205, 278, 350, 420, 488, 555, 617, 680};
  localparam int unsigned RunBase  [10] = '{1, 32, 77, 137, 203, 273, 343, 409, 469, 514};
  localparam bit          RunDown  [10] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] index;
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] color;
  } pixel_cmd_t;

  typedef struct packed {
    logic [23:0] read_color;
    logic [7:0]  out_byte;
    logic        last_byte;
  } strand_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [10:0] cfg_wdata_i = '0;
  logic        start_i     = 1'b0;
  logic [2:0]  mode_i        = '0;
  logic [15:0] pixel_index_i = '0;
  logic [15:0] x_coord_i     = '0;
  logic [15:0] y_coord_i     = '0;
  logic [23:0] color_i       = '0;
  logic        busy_o;
  logic        done_o;
  logic [23:0] read_color_o;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;

  // Predictor state: register copies, frame store and shift position
  logic        cfg_grb;
  logic        cfg_side_on;
  logic [9:0]  cfg_height;
  logic [10:0] cfg_pcount;
  logic [7:0]  cfg_level;
  logic [23:0] frame_mem [StoreDepth];
  int unsigned shift_pos;

  pixel_cmd_t     pending_q [$];
  strand_result_t expected_q [$];
  int unsigned    touched_idx [$];
  pixel_cmd_t     cmd_now;
  int             idle_pct     = 31;
  int             mismatches   = 0;
  int             quiet_cycles = 0;

  led_strand_frame_remapper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .pixel_index_i (pixel_index_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .color_i       (color_i),
    .done_o        (done_o),
    .read_color_o  (read_color_o),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned store_limit();
    return (cfg_pcount < StoreDepth) ? int'(cfg_pcount) : StoreDepth;
  endfunction

  // RRGGBB <-> GGRRBB
  function automatic logic [23:0] swap_rg(logic [23:0] c);
    return {c[15:8], c[23:16], c[7:0]};
  endfunction

  // Virtual pixel shown at physical pixel phys; later matches take priority
  function automatic bit board_source(int unsigned phys, output int unsigned vpix);
    int unsigned n, m, lim, d, px, t;
    bit          hit;
    hit  = 1'b0;
    vpix = 0;
    lim  = store_limit();
    n    = phys + 1;
    if (!cfg_side_on) m = n;
    else m = (n > EdgePixels) ? n - EdgePixels : 0;
    if (m >= 1) begin
      for (int s = 0; s < 10; s++) begin
        if (m >= RunBase[s] && m <= RunBase[s] + RunLast[s] - RunFirst[s]) begin
          d  = m - RunBase[s];
          px = RunDown[s] ? RunLast[s] - d : RunFirst[s] + d;
          if (px - 1 < lim) begin
            vpix = px - 1;
            hit  = 1'b1;
          end
        end
      end
    end
    if (cfg_side_on) begin
      // mirrored side strips: first half counts up, second half counts down
      if (n - 1 < EdgePixels / 2 && EdgeBase + n - 1 < lim) begin
        vpix = EdgeBase + n - 1;
        hit  = 1'b1;
      end
      if (n <= EdgePixels) begin
        t = EdgePixels + EdgePixels / 2 - n;
        if (EdgeBase + t < lim) begin
          vpix = EdgeBase + t;
          hit  = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic strand_result_t apply_command(pixel_cmd_t c);
    strand_result_t r;
    int unsigned    addr, lim, row, hgt, vsrc, divisor;
    logic [7:0]     raw;
    r    = '0;
    lim  = store_limit();
    hgt  = cfg_height;
    addr = c.index;
    if (c.mode == MODE_WR_XY || c.mode == MODE_RD_XY) begin
      row  = (hgt == 0) ? c.y : c.y % hgt;
      addr = (row + c.x * hgt) & 32'hFFFF;
    end
    case (c.mode)
      MODE_WR_IDX, MODE_WR_XY: begin
        if (addr < lim) frame_mem[addr] = cfg_grb ? swap_rg(c.color) : c.color;
      end
      MODE_RD_IDX, MODE_RD_XY: begin
        if (addr < lim) r.read_color = cfg_grb ? swap_rg(frame_mem[addr]) : frame_mem[addr];
      end
      MODE_SHIFT: begin
        if (shift_pos < FrameBytes && board_source(shift_pos / 3, vsrc)) begin
          raw        = 8'(frame_mem[vsrc] >> (16 - 8 * (shift_pos % 3)));
          divisor    = (cfg_level == 0) ? 255 : 255 / cfg_level;
          r.out_byte = 8'(raw / divisor);
        end
        if (shift_pos + 1 >= FrameBytes) begin
          r.last_byte = 1'b1;
          shift_pos   = 0;
        end else begin
          shift_pos = shift_pos + 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(logic [2:0] mode, logic [15:0] index, logic [15:0] x,
                                    logic [15:0] y, logic [23:0] color);
    pixel_cmd_t c;
    c = '{mode, index, x, y, color};
    pending_q.push_back(c);
  endfunction

  // Mostly well-formed traffic: valid addresses, re-reads of written pixels,
  // in-range x,y, shift bursts; the rest out of range or undefined
  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t  c;
    int unsigned lim, pick, hgt;
    lim     = store_limit();
    hgt     = cfg_height;
    c.index = 16'($urandom);
    c.x     = 16'($urandom);
    c.y     = 16'($urandom);
    c.color = 24'($urandom);
    pick    = $urandom_range(99);
    if (pick < 22) c.mode = MODE_WR_IDX;
    else if (pick < 34) c.mode = MODE_WR_XY;
    else if (pick < 52) c.mode = MODE_RD_IDX;
    else if (pick < 62) c.mode = MODE_RD_XY;
    else if (pick < 97) c.mode = MODE_SHIFT;
    else c.mode = 3'(MODE_SHIFT) + 3'($urandom_range(1, 3));

    if ((c.mode == MODE_WR_IDX || c.mode == MODE_RD_IDX) && lim != 0 &&
        $urandom_range(9) < 8) begin
      if (c.mode == MODE_RD_IDX && touched_idx.size() != 0 && $urandom_range(1) == 1)
        c.index = 16'(touched_idx[$urandom_range(touched_idx.size() - 1)]);
      else
        c.index = 16'($urandom_range(lim - 1));
    end
    if ((c.mode == MODE_WR_XY || c.mode == MODE_RD_XY) && $urandom_range(4) != 0) begin
      c.x = 16'($urandom_range(80));
      c.y = 16'($urandom_range(2 * hgt + 1));
    end
    if (c.mode == MODE_WR_IDX) touched_idx.push_back(c.index);
    return c;
  endfunction

  task automatic write_reg(cfg_idx_e which, int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= which;
    cfg_wdata_i <= 11'(value);
    case (which)
      CFG_GRB_ORDER:  cfg_grb     = value[0];
      CFG_SIDE_ON:    cfg_side_on = value[0];
      CFG_HEIGHT:     cfg_height  = 10'(value);
      CFG_PIX_COUNT:  cfg_pcount  = 11'(value);
      CFG_BRIGHTNESS: cfg_level   = 8'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned grb, int unsigned side, int unsigned hgt,
                                int unsigned pcount, int unsigned level);
    write_reg(CFG_GRB_ORDER, grb);
    write_reg(CFG_SIDE_ON, side);
    write_reg(CFG_HEIGHT, hgt);
    write_reg(CFG_PIX_COUNT, pcount);
    write_reg(CFG_BRIGHTNESS, level);
    @(negedge clk_i);
  endtask

  // Block idle: nothing queued, nothing offered, every result back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || start_i || expected_q.size() != 0 || busy_o);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending_q.push_back(random_cmd());
    drain();
  endtask

  always @(posedge clk_i) begin : cmd_driver
    strand_result_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        want = apply_command(cmd_now);
        expected_q.push_back(want);
      end
      if (!start_i || !busy_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cmd_now        = pending_q.pop_front();
          start_i       <= 1'b1;
          mode_i        <= cmd_now.mode;
          pixel_index_i <= cmd_now.index;
          x_coord_i     <= cmd_now.x;
          y_coord_i     <= cmd_now.y;
          color_i       <= cmd_now.color;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    strand_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (read_color_o !== want.read_color) begin
          $error("read_color: expected %06h, got %06h", want.read_color, read_color_o);
          mismatches++;
        end
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte_o);
          mismatches++;
        end
        if (last_byte_o !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, last_byte_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : stall_counter
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : sequencer
    cfg_grb     = 1'b0;
    cfg_side_on = 1'b1;
    cfg_height  = 10'd10;
    cfg_pcount  = 11'd858;
    cfg_level   = 8'd255;
    shift_pos   = 0;
    for (int i = 0; i < StoreDepth; i++) frame_mem[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // store is swept clear after reset with busy high
    drain();

    // Directed: store bounds, x,y wrap, shift of the first edge pixel, undefined modes
    queue_cmd(MODE_WR_IDX, 16'd0, 16'd0, 16'd0, 24'h123456);
    queue_cmd(MODE_WR_IDX, 16'd857, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    queue_cmd(MODE_WR_IDX, 16'd858, 16'd0, 16'd0, 24'hABCDEF);
    queue_cmd(MODE_WR_IDX, 16'hFFFF, 16'd0, 16'd0, 24'h000001);
    queue_cmd(MODE_WR_IDX, 16'd700, 16'd0, 16'd0, 24'h80FF01);
    queue_cmd(MODE_RD_IDX, 16'd0, 16'd0, 16'd0, 24'd0);
    queue_cmd(MODE_RD_IDX, 16'd857, 16'd0, 16'd0, 24'd0);
    queue_cmd(MODE_RD_IDX, 16'd858, 16'd0, 16'd0, 24'd0);
    queue_cmd(MODE_RD_IDX, 16'hFFFF, 16'd0, 16'd0, 24'd0);
    queue_cmd(MODE_WR_XY, 16'd0, 16'd3, 16'd27, 24'h00FF00);
    queue_cmd(MODE_RD_XY, 16'd0, 16'd3, 16'd7, 24'd0);
    queue_cmd(MODE_WR_XY, 16'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    queue_cmd(MODE_RD_XY, 16'd0, 16'hFFFF, 16'hFFFF, 24'd0);
    for (int i = 0; i < 3; i++) queue_cmd(MODE_SHIFT, 16'd0, 16'd0, 16'd0, 24'd0);
    for (int i = 1; i <= 3; i++)
      queue_cmd(3'(MODE_SHIFT) + 3'(i), 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    queue_cmd(MODE_RD_IDX, 16'd700, 16'd0, 16'd0, 24'd0);
    drain();

    // Swapped byte order and zero height (y used as the row directly)
    write_reg(CFG_GRB_ORDER, 1);
    write_reg(CFG_HEIGHT, 0);
    @(negedge clk_i);
    queue_cmd(MODE_RD_IDX, 16'd0, 16'd0, 16'd0, 24'd0);
    queue_cmd(MODE_WR_XY, 16'd0, 16'd9, 16'd300, 24'hA1B2C3);
    queue_cmd(MODE_RD_IDX, 16'd300, 16'd0, 16'd0, 24'd0);
    drain();

    // Random traffic across register settings, extremes included
    apply_settings(0, 1, 10, 858, 255);
    run_random(PhaseItems);
    apply_settings(1, 1, 1, 1024, 1);
    run_random(PhaseItems);
    idle_pct = 0;
    apply_settings(0, 0, 1023, 0, 0);
    run_random(PhaseItems);
    idle_pct = 31;
    apply_settings(1, 0, 0, 2047, 128);
    run_random(PhaseItems);
    apply_settings(0, 1, 37, 937, 127);
    run_random(PhaseItems);
    apply_settings(1, 1, 10, 700, 2);
    run_random(PhaseItems);
    apply_settings(0, 0, 70, 512, 200);
    run_random(PhaseItems);
    apply_settings(1, 1, 5, 1024, 77);
    run_random(PhaseItems);

    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/lsfr_pkg.sv
design/lsfr_ram.sv
design/led_strand_frame_remapper.sv
tb/tb_led_strand_frame_remapper.sv
